### design/corm_pkg.sv
package corm_pkg;

	// Sizes fixed by the item and register formats
	localparam int unsigned NUM_CHANNELS_DEF = 64;
	localparam int unsigned CH_W   = 6;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned Q_W    = 32;
	localparam int unsigned SUM_W  = 44;
	localparam int unsigned WP_W   = 12;
	localparam int unsigned CIU_W  = 7;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// Shared divider: one quotient bit per cycle over the window sum width
	localparam int unsigned DIV_N  = SUM_W;
	localparam int unsigned DIV_CW = $clog2(DIV_N);

	localparam logic [CNT_W-1:0] CNT_MAX  = '1;
	localparam logic [Q_W-1:0]   RATE_MAX = '1;

	// Register reset values
	localparam logic [WP_W-1:0]  WP_RST   = WP_W'(100);
	localparam logic             NORM_RST = 1'b1;
	localparam logic [CIU_W-1:0] CIU_RST  = CIU_W'(64);

	// Input action codes
	localparam logic ACT_HIT = 1'b0;
	localparam logic ACT_EOP = 1'b1;

	// Register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_WINDOW_PACKETS = 2'd0,
		REG_NORMALIZE      = 2'd1,
		REG_CHANNELS       = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [WP_W-1:0]  window_packets;
		logic             normalize_enable;
		logic [CIU_W-1:0] channels_in_use;
	} cfg_t;

	// Store controls from the sequencer
	typedef struct packed {
		logic pkt_rd;
		logic pkt_we;
		logic pkt_clr;
		logic win_rd;
		logic win_we;
		logic win_clr;
	} st_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HIT_RD,
		ST_HIT_WR,
		ST_EOP_RD,
		ST_EOP_CALC,
		ST_EOP_DIV,
		ST_EOP_WR,
		ST_EOP_END,
		ST_WIN_RD,
		ST_WIN_CALC,
		ST_WIN_DIV,
		ST_WIN_OUT,
		ST_WIN_END
	} state_t;

endpackage

### design/corm_if.sv
// Hit / end-of-packet channel
interface corm_in_if;
	import corm_pkg::*;

	logic            valid;
	logic            ready;
	logic            action;
	logic [CH_W-1:0] hit_channel;
	logic            hit_is_outlier;

	modport source(output valid, action, hit_channel, hit_is_outlier, input ready);
	modport sink(input valid, action, hit_channel, hit_is_outlier, output ready);
endinterface

// Averaged rate result channel
interface corm_out_if;
	import corm_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] rate_channel;
	logic [Q_W-1:0]  average_rate;
	logic            last_channel;

	modport source(output valid, rate_channel, average_rate, last_channel, input ready);
	modport sink(input valid, rate_channel, average_rate, last_channel, output ready);
endinterface

### design/corm_cfg.sv
module corm_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [corm_pkg::ADDR_W-1:0] paddr,
	input  logic [corm_pkg::DATA_W-1:0] pwdata,
	output logic [corm_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output corm_pkg::cfg_t              cfg
);
	import corm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_packets   <= WP_RST;
			cfg_q.normalize_enable <= NORM_RST;
			cfg_q.channels_in_use  <= CIU_RST;
		end else if (wr_en) begin
			case (idx)
				REG_WINDOW_PACKETS: cfg_q.window_packets   <= pwdata[WP_W-1:0];
				REG_NORMALIZE:      cfg_q.normalize_enable <= pwdata[0];
				REG_CHANNELS:       cfg_q.channels_in_use  <= pwdata[CIU_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		case (idx)
			REG_WINDOW_PACKETS: prdata = DATA_W'(cfg_q.window_packets);
			REG_NORMALIZE:      prdata = DATA_W'(cfg_q.normalize_enable);
			REG_CHANNELS:       prdata = DATA_W'(cfg_q.channels_in_use);
			default:            prdata = '0;
		endcase
	end

endmodule

### design/corm_div.sv
// Restoring divider, one quotient bit per cycle; done pulses when quotient is final
module corm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [corm_pkg::SUM_W-1:0] dividend,
	input  logic [corm_pkg::CNT_W-1:0] divisor,
	output logic                       done,
	output logic [corm_pkg::SUM_W-1:0] quotient
);
	import corm_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [CNT_W-1:0]  rem_q;

	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             ge;
	logic [CNT_W-1:0] rem_nx;

	// One trial subtract
	always_comb begin
		trial  = {rem_q, dvd_q[SUM_W-1]};
		diff   = trial - {1'b0, dsr_q};
		ge     = (trial >= {1'b0, dsr_q});
		rem_nx = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
	end

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder; quotient bits shift in from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

### design/corm_store.sv
// Per-channel packet counts and window sums, one port each, registered read
module corm_store #(
	parameter int unsigned NUM_CHANNELS = corm_pkg::NUM_CHANNELS_DEF,
	localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  corm_pkg::st_ctl_t            ctl,
	input  logic [AW-1:0]                addr,
	input  logic [2*corm_pkg::CNT_W-1:0] pkt_wdata,
	input  logic [corm_pkg::SUM_W-1:0]   win_wdata,
	output logic [2*corm_pkg::CNT_W-1:0] pkt_rdata,
	output logic [corm_pkg::SUM_W-1:0]   win_rdata
);
	import corm_pkg::*;

	logic [2*CNT_W-1:0] pkt_mem [NUM_CHANNELS];
	logic [SUM_W-1:0]   win_mem [NUM_CHANNELS];

	logic [NUM_CHANNELS-1:0] pkt_vld_q;
	logic [NUM_CHANNELS-1:0] win_vld_q;

	logic [2*CNT_W-1:0] pkt_rd_s1;
	logic [SUM_W-1:0]   win_rd_s1;
	logic               pkt_rv_s1;
	logic               win_rv_s1;

	// Memory arrays
	always_ff @(posedge clk) begin
		if (ctl.pkt_we) begin
			pkt_mem[addr] <= pkt_wdata;
		end
		if (ctl.pkt_rd) begin
			pkt_rd_s1 <= pkt_mem[addr];
		end
		if (ctl.win_we) begin
			win_mem[addr] <= win_wdata;
		end
		if (ctl.win_rd) begin
			win_rd_s1 <= win_mem[addr];
		end
	end

	// Entry valid bits: an entry not written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_vld_q <= '0;
			win_vld_q <= '0;
			pkt_rv_s1 <= 1'b0;
			win_rv_s1 <= 1'b0;
		end else begin
			if (ctl.pkt_clr) begin
				pkt_vld_q <= '0;
			end else if (ctl.pkt_we) begin
				pkt_vld_q[addr] <= 1'b1;
			end
			if (ctl.win_clr) begin
				win_vld_q <= '0;
			end else if (ctl.win_we) begin
				win_vld_q[addr] <= 1'b1;
			end
			if (ctl.pkt_rd) begin
				pkt_rv_s1 <= pkt_vld_q[addr];
			end
			if (ctl.win_rd) begin
				win_rv_s1 <= win_vld_q[addr];
			end
		end
	end

	assign pkt_rdata = pkt_rv_s1 ? pkt_rd_s1 : '0;
	assign win_rdata = win_rv_s1 ? win_rd_s1 : '0;

endmodule

### design/channel_outlier_rate_monitor_unit.sv
// Per-channel outlier rate monitor. Hit beats count hits and outlier hits per
// channel in a packet-count memory; each hit is a read-modify-write of that
// memory (a read state, then a write-back state), and a hit may be accepted in
// the write-back cycle of the one before. An end-of-packet beat starts a walk
// over the channels in use: per channel a read and a calculate step, then,
// when normalization is on and the channel saw hits, the bit-serial divide
// (one quotient bit per cycle over 44 bits) that forms the Q16.16 outlier
// fraction added to the channel's window sum, then a write, and one closing
// step per packet. When the window closes, a second walk divides each window
// sum by window_packets on the same divider and sends one result beat per
// channel, in channel order, with last_channel on the final one; a stalled
// result holds up that walk only.
// No hit is taken during either walk. Stores clear through per-entry valid
// bits, so there is no clearing pass after reset. Registers sit at byte
// address 0 (window_packets), 4 (normalize_enable) and 8 (channels_in_use)
// and should be written only while the block is idle.
module channel_outlier_rate_monitor_unit #(
	parameter int unsigned NUM_CHANNELS = corm_pkg::NUM_CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	corm_in_if.sink                     hits,
	corm_out_if.source                  rates,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [corm_pkg::ADDR_W-1:0] paddr,
	input  logic [corm_pkg::DATA_W-1:0] pwdata,
	output logic [corm_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import corm_pkg::*;

	localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CIU_W-1:0] NCH = CIU_W'(NUM_CHANNELS);

	cfg_t    cfg;
	st_ctl_t ctl;
	state_t  state_q, state_d;

	logic [AW-1:0]   cnt_q;
	logic [AW-1:0]   ch_q;
	logic            outl_q;
	logic [WP_W-1:0] ps_q;
	logic [Q_W-1:0]  q_q;
	logic [Q_W-1:0]  avg_q;

	logic            out_valid_q;
	logic [CH_W-1:0] out_ch_q;
	logic [Q_W-1:0]  out_rate_q;
	logic            out_last_q;

	logic [AW-1:0]      st_addr;
	logic [2*CNT_W-1:0] pkt_wdata, pkt_rdata;
	logic [SUM_W-1:0]   win_wdata, win_rdata;

	logic             div_start, div_done;
	logic [SUM_W-1:0] div_dividend, div_quot;
	logic [CNT_W-1:0] div_divisor;

	logic [CIU_W-1:0] used, used_m1;
	logic [WP_W-1:0]  wp_eff, ps_next;
	logic             last_ch, in_range, accept, win_close, need_div, out_free;
	logic [CNT_W-1:0] pkt_o, pkt_h, o_inc, h_inc;

	corm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	corm_store #(.NUM_CHANNELS(NUM_CHANNELS)) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.addr      (st_addr),
		.pkt_wdata (pkt_wdata),
		.win_wdata (win_wdata),
		.pkt_rdata (pkt_rdata),
		.win_rdata (win_rdata)
	);

	corm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Effective channel count and window length
	always_comb begin
		used = cfg.channels_in_use;
		if (used == '0) begin
			used = CIU_W'(1);
		end
		if (used > NCH) begin
			used = NCH;
		end
		used_m1 = used - 1'b1;
		wp_eff  = (cfg.window_packets == '0) ? WP_W'(1) : cfg.window_packets;
	end

	assign last_ch   = (CIU_W'(cnt_q) == used_m1);
	assign in_range  = ({1'b0, hits.hit_channel} < used);
	assign accept    = hits.valid && hits.ready;
	assign ps_next   = ps_q + 1'b1;
	assign win_close = (ps_next >= wp_eff) || (ps_next == '0);
	assign out_free  = !out_valid_q || rates.ready;

	// Count update for one hit, both saturating
	assign pkt_o    = pkt_rdata[2*CNT_W-1:CNT_W];
	assign pkt_h    = pkt_rdata[CNT_W-1:0];
	assign need_div = cfg.normalize_enable && (pkt_h != '0);
	assign h_inc    = (pkt_h != CNT_MAX) ? pkt_h + 1'b1 : pkt_h;
	assign o_inc    = (outl_q && pkt_o != CNT_MAX) ? pkt_o + 1'b1 : pkt_o;

	// Store datapath
	assign st_addr   = (state_q == ST_HIT_RD || state_q == ST_HIT_WR) ? ch_q : cnt_q;
	assign pkt_wdata = {o_inc, h_inc};
	assign win_wdata = win_rdata + SUM_W'(q_q);

	// Divider operands: window average or outlier fraction
	always_comb begin
		if (state_q == ST_WIN_CALC) begin
			div_dividend = win_rdata;
			div_divisor  = CNT_W'(wp_eff);
		end else begin
			div_dividend = SUM_W'({pkt_o, {CNT_W{1'b0}}});
			div_divisor  = pkt_h;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE, ST_HIT_WR: begin
				state_d = ST_IDLE;
				if (accept) begin
					if (hits.action == ACT_EOP) begin
						state_d = ST_EOP_RD;
					end else if (in_range) begin
						state_d = ST_HIT_RD;
					end
				end
			end
			ST_HIT_RD:   state_d = ST_HIT_WR;
			ST_EOP_RD:   state_d = ST_EOP_CALC;
			ST_EOP_CALC: state_d = need_div ? ST_EOP_DIV : ST_EOP_WR;
			ST_EOP_DIV: begin
				if (div_done) begin
					state_d = ST_EOP_WR;
				end
			end
			ST_EOP_WR:   state_d = last_ch ? ST_EOP_END : ST_EOP_RD;
			ST_EOP_END:  state_d = win_close ? ST_WIN_RD : ST_IDLE;
			ST_WIN_RD:   state_d = ST_WIN_CALC;
			ST_WIN_CALC: state_d = ST_WIN_DIV;
			ST_WIN_DIV: begin
				if (div_done) begin
					state_d = ST_WIN_OUT;
				end
			end
			ST_WIN_OUT: begin
				if (out_free) begin
					state_d = last_ch ? ST_WIN_END : ST_WIN_RD;
				end
			end
			ST_WIN_END:  state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		hits.ready = 1'b0;
		ctl        = '0;
		div_start  = 1'b0;
		case (state_q)
			ST_IDLE:     hits.ready = 1'b1;
			ST_HIT_RD:   ctl.pkt_rd = 1'b1;
			ST_HIT_WR: begin
				hits.ready = 1'b1;
				ctl.pkt_we = 1'b1;
			end
			ST_EOP_RD: begin
				ctl.pkt_rd = 1'b1;
				ctl.win_rd = 1'b1;
			end
			ST_EOP_CALC: div_start  = need_div;
			ST_EOP_WR:   ctl.win_we = 1'b1;
			ST_EOP_END:  ctl.pkt_clr = 1'b1;
			ST_WIN_RD:   ctl.win_rd = 1'b1;
			ST_WIN_CALC: div_start  = 1'b1;
			ST_WIN_END: begin
				ctl.pkt_clr = 1'b1;
				ctl.win_clr = 1'b1;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ps_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && hits.action == ACT_EOP) begin
				cnt_q <= '0;
			end else if (state_q == ST_EOP_WR && !last_ch) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == ST_EOP_END) begin
				cnt_q <= '0;
			end else if (state_q == ST_WIN_OUT && out_free && !last_ch) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_EOP_END) begin
				ps_q <= ps_next;
			end else if (state_q == ST_WIN_END) begin
				ps_q <= '0;
			end
			if (state_q == ST_WIN_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rates.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q   <= hits.hit_channel[AW-1:0];
			outl_q <= hits.hit_is_outlier;
		end
		if (state_q == ST_EOP_CALC && !need_div) begin
			q_q <= {pkt_o, {CNT_W{1'b0}}};
		end else if (state_q == ST_EOP_DIV && div_done) begin
			q_q <= div_quot[Q_W-1:0];
		end
		if (state_q == ST_WIN_DIV && div_done) begin
			avg_q <= (div_quot[SUM_W-1:Q_W] != '0) ? RATE_MAX : div_quot[Q_W-1:0];
		end
		if (state_q == ST_WIN_OUT && out_free) begin
			out_ch_q   <= CH_W'(cnt_q);
			out_rate_q <= avg_q;
			out_last_q <= last_ch;
		end
	end

	assign rates.valid        = out_valid_q;
	assign rates.rate_channel = out_ch_q;
	assign rates.average_rate = out_rate_q;
	assign rates.last_channel = out_last_q;

endmodule

### design/corm_checker.sv
module corm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [corm_pkg::CH_W-1:0] rate_channel,
	input logic [corm_pkg::Q_W-1:0]  average_rate,
	input logic                      last_channel
);
	import corm_pkg::*;

	logic [CH_W-1:0] exp_ch_q;

	// Expected channel of the next result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_ch_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_ch_q <= last_channel ? '0 : rate_channel + 1'b1;
		end
	end

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rate_channel)
			&& $stable(average_rate) && $stable(last_channel))
		else $error("result beat changed while stalled");

	// Results of a window come in channel order from zero
	a_ch_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rate_channel == exp_ch_q)
		else $error("result channel out of order");

	// No hit is taken while a result beat other than the last of a window is pending
	a_busy_walk: assert property (@(posedge clk)
		out_valid && !last_channel |-> !in_ready)
		else $error("input ready during window report");

	// Reset empties the result register
	a_rst_out: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind channel_outlier_rate_monitor_unit corm_checker u_corm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (hits.ready),
	.out_valid    (rates.valid),
	.out_ready    (rates.ready),
	.rate_channel (rates.rate_channel),
	.average_rate (rates.average_rate),
	.last_channel (rates.last_channel)
);
